// File: src/iir_lpf_pkg.sv
// Shared types and constants for the 8th-order Butterworth lowpass IIR.
// Holds the fixed coefficient tables, widths and the controller command bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iir_lpf_pkg;

  // defaults for the top-level parameters
  localparam int NUM_TAPS_DEF     = 9;
  localparam int DEN_TAPS_DEF     = 9;
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int STATE_WIDTH_DEF  = 64;

  localparam int MAX_TAPS = 16;
  localparam int TAP_W    = $clog2(MAX_TAPS);
  localparam int COEF_W   = 64;
  localparam int HALF_W   = COEF_W / 2;
  localparam int MUL_W    = HALF_W + 1;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 2 * COEF_W;
  localparam int SHIFT_W  = $clog2(ACC_W);
  localparam int CFRAC    = 56;

  // partial product select: bit 0 picks the coefficient half, bit 1 the data half
  localparam logic [1:0] PART_FIRST    = 2'd0;
  localparam logic [1:0] PART_LAST_NUM = 2'd1;
  localparam logic [1:0] PART_LAST_DEN = 2'd3;

  typedef struct packed {
    logic             start;   // new sample taken, clear accumulator
    logic             issue;   // partial product issued this cycle
    logic             den;     // feedback tap
    logic [TAP_W-1:0] tap;
    logic [1:0]       part;
    logic             round;   // form y and shift the histories
    logic             finish;  // load the output register
  } cmd_t;

  // powers of ten
  localparam logic [ACC_W-1:0] P10_12 = 128'd1000000000000;
  localparam logic [ACC_W-1:0] P10_11 = P10_12 / 10;
  localparam logic [ACC_W-1:0] P10_13 = P10_12 * 10;
  localparam logic [ACC_W-1:0] P10_21 = P10_12 * 128'd1000000000;
  localparam logic [ACC_W-1:0] P10_22 = P10_21 * 10;
  localparam logic [ACC_W-1:0] P10_23 = P10_22 * 10;
  localparam logic [ACC_W-1:0] P10_24 = P10_23 * 10;

  // magnitudes, round(m * 2^56 / 10^d) half away from zero
  localparam logic [ACC_W-1:0] NC0_M =
    ((128'd5285919273356 << CFRAC) + (P10_24 >> 1)) / P10_24;
  localparam logic [ACC_W-1:0] NC1_M =
    ((128'd4228735418685 << CFRAC) + (P10_23 >> 1)) / P10_23;
  localparam logic [ACC_W-1:0] NC2_M =
    ((128'd148005739654 << CFRAC) + (P10_21 >> 1)) / P10_21;
  localparam logic [ACC_W-1:0] NC3_M =
    ((128'd2960114793079 << CFRAC) + (P10_22 >> 1)) / P10_22;
  localparam logic [ACC_W-1:0] NC4_M =
    ((128'd3700143491349 << CFRAC) + (P10_22 >> 1)) / P10_22;

  localparam logic [ACC_W-1:0] DC1_M =
    ((128'd7590687094437 << CFRAC) + (P10_12 >> 1)) / P10_12;
  localparam logic [ACC_W-1:0] DC2_M =
    ((128'd2521812014273 << CFRAC) + (P10_11 >> 1)) / P10_11;
  localparam logic [ACC_W-1:0] DC3_M =
    ((128'd4789335424121 << CFRAC) + (P10_11 >> 1)) / P10_11;
  localparam logic [ACC_W-1:0] DC4_M =
    ((128'd5687002612068 << CFRAC) + (P10_11 >> 1)) / P10_11;
  localparam logic [ACC_W-1:0] DC5_M =
    ((128'd4323484983982 << CFRAC) + (P10_11 >> 1)) / P10_11;
  localparam logic [ACC_W-1:0] DC6_M =
    ((128'd2055056514782 << CFRAC) + (P10_11 >> 1)) / P10_11;
  localparam logic [ACC_W-1:0] DC7_M =
    ((128'd558382515593 << CFRAC) + (P10_11 >> 1)) / P10_11;
  localparam logic [ACC_W-1:0] DC8_M =
    ((128'd6640049215241 << CFRAC) + (P10_13 >> 1)) / P10_13;

  localparam logic [COEF_W-1:0] NUM_COEF [MAX_TAPS] = '{
    COEF_W'(NC0_M), COEF_W'(NC1_M), COEF_W'(NC2_M), COEF_W'(NC3_M),
    COEF_W'(NC4_M), COEF_W'(NC3_M), COEF_W'(NC2_M), COEF_W'(NC1_M),
    COEF_W'(NC0_M), '0, '0, '0, '0, '0, '0, '0
  };

  // leading denominator term is 1 and never used
  localparam logic [COEF_W-1:0] DEN_COEF [MAX_TAPS] = '{
    '0,
    COEF_W'(ACC_W'(0) - DC1_M), COEF_W'(DC2_M),
    COEF_W'(ACC_W'(0) - DC3_M), COEF_W'(DC4_M),
    COEF_W'(ACC_W'(0) - DC5_M), COEF_W'(DC6_M),
    COEF_W'(ACC_W'(0) - DC7_M), COEF_W'(DC8_M),
    '0, '0, '0, '0, '0, '0, '0
  };

endpackage

`default_nettype wire

// File: src/iir_lpf_if.sv
// Valid/ready stream interfaces for the IIR lowpass sample channels.
// Depends on iir_lpf_pkg for the default sample width.
`timescale 1ns / 1ps
`default_nettype none

interface iir_lpf_in_if import iir_lpf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iir_lpf_out_if import iir_lpf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

// File: src/iir_lpf_ctrl.sv
// Sequencer for the IIR lowpass: walks numerator and feedback taps through
// the shared multiplier, then rounding and output load. Uses iir_lpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iir_lpf_ctrl import iir_lpf_pkg::*; #(
  parameter int NUM_TAPS = NUM_TAPS_DEF,
  parameter int DEN_TAPS = DEN_TAPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic out_free_i,
  output cmd_t cmd_o
);

  localparam int NT_USE = (NUM_TAPS > MAX_TAPS) ? MAX_TAPS : NUM_TAPS;
  localparam int DT_USE = (DEN_TAPS > MAX_TAPS) ? MAX_TAPS : DEN_TAPS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAC   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_FINAL = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;
  logic [1:0]       part_q, part_d;
  logic             den_q, den_d;
  logic             accept;
  logic             last_part;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign last_part  = den_q ? (part_q == PART_LAST_DEN) : (part_q == PART_LAST_NUM);

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    part_d  = part_q;
    den_d   = den_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MAC;
          tap_d   = '0;
          part_d  = PART_FIRST;
          den_d   = 1'b0;
        end
      end
      ST_MAC: begin
        if (!last_part) begin
          part_d = part_q + 2'd1;
        end else begin
          part_d = PART_FIRST;
          if (den_q) begin
            if (tap_q == TAP_W'(DT_USE - 1)) begin
              state_d = ST_DRAIN;
            end else begin
              tap_d = tap_q + TAP_W'(1);
            end
          end else if (tap_q == TAP_W'(NT_USE - 1)) begin
            // feedback taps start at index one
            den_d = 1'b1;
            tap_d = TAP_W'(1);
          end else begin
            tap_d = tap_q + TAP_W'(1);
          end
        end
      end
      ST_DRAIN: state_d = ST_ROUND;
      ST_ROUND: state_d = ST_FINAL;
      ST_FINAL: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
      part_q  <= PART_FIRST;
      den_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      part_q  <= part_d;
      den_q   <= den_d;
    end
  end

  always_comb begin
    cmd_o.start  = accept;
    cmd_o.issue  = (state_q == ST_MAC);
    cmd_o.den    = den_q;
    cmd_o.tap    = tap_q;
    cmd_o.part   = part_q;
    cmd_o.round  = (state_q == ST_ROUND);
    cmd_o.finish = (state_q == ST_FINAL) & out_free_i;
  end

endmodule

`default_nettype wire

// File: src/iir_lpf_dp.sv
// Datapath for the IIR lowpass: sample histories, 33x33 partial-product
// multiplier, 128-bit accumulator, rounding/saturation and output register.
// Driven by iir_lpf_ctrl commands; uses iir_lpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iir_lpf_dp import iir_lpf_pkg::*; #(
  parameter int NUM_TAPS     = NUM_TAPS_DEF,
  parameter int DEN_TAPS     = DEN_TAPS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                    clipped_o,
  output logic                    out_free_o
);

  localparam int NT_USE    = (NUM_TAPS > MAX_TAPS) ? MAX_TAPS : NUM_TAPS;
  localparam int DT_USE    = (DEN_TAPS > MAX_TAPS) ? MAX_TAPS : DEN_TAPS;
  localparam int IN_DEPTH  = NT_USE - 1;
  localparam int OUT_DEPTH = DT_USE - 1;
  // Q1.(SW-1) input aligned to Q8.56, Q8.(ST-8) history aligned to Q8.56
  localparam int NUM_SH_LO = CFRAC + 1 - SAMPLE_WIDTH;
  localparam int NUM_SH_HI = NUM_SH_LO + HALF_W;
  localparam int D_SH      = COEF_W - STATE_WIDTH;
  localparam int Y_SH      = 2 * CFRAC + 8 - STATE_WIDTH;
  localparam int S_SH      = STATE_WIDTH - 7 - SAMPLE_WIDTH;
  localparam int EXT_W     = COEF_W + 1;

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [SAMPLE_WIDTH-1:0] in_hist_q  [IN_DEPTH];
  logic signed [STATE_WIDTH-1:0]  out_hist_q [OUT_DEPTH];

  // operand select
  logic        [COEF_W-1:0]       coef;
  logic signed [SAMPLE_WIDTH-1:0] in_sel;
  logic signed [SAMPLE_WIDTH-1:0] x_sel;
  logic signed [STATE_WIDTH-1:0]  out_sel;
  logic        [COEF_W-1:0]       d_word;
  logic signed [MUL_W-1:0]        a_op, b_op;
  logic signed [PROD_W-1:0]       prod_d;
  logic        [SHIFT_W-1:0]      sh_d;

  logic signed [PROD_W-1:0]  prod_q;
  logic        [SHIFT_W-1:0] sh_q;
  logic                      neg_q;
  logic                      pvld_q;

  logic [ACC_W-1:0] acc_q, acc_d, ext;

  logic        [ACC_W-1:0]       y_rnd;
  logic signed [ACC_W-1:0]       y_shr;
  logic        [ACC_W-STATE_WIDTH:0] y_top;
  logic                          y_fit;
  logic signed [STATE_WIDTH-1:0] y_d, y_q;

  logic        [EXT_W-1:0]          s_rnd;
  logic signed [EXT_W-1:0]          s_shr;
  logic        [EXT_W-SAMPLE_WIDTH:0] s_top;
  logic                             s_fit;
  logic        [SAMPLE_WIDTH-1:0]   s_d;

  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] sample_out_q;
  logic                    clipped_q;

  // history taps picked by tap index (tap k reads history entry k-1)
  always_comb begin
    in_sel  = '0;
    out_sel = '0;
    for (int i = 0; i < IN_DEPTH; i++) begin
      if (cmd_i.tap == TAP_W'(i + 1)) in_sel = in_hist_q[i];
    end
    for (int i = 0; i < OUT_DEPTH; i++) begin
      if (cmd_i.tap == TAP_W'(i + 1)) out_sel = out_hist_q[i];
    end
  end

  assign x_sel  = (cmd_i.tap == '0) ? x_q : in_sel;
  assign coef   = cmd_i.den ? DEN_COEF[cmd_i.tap] : NUM_COEF[cmd_i.tap];
  assign d_word = COEF_W'(out_sel) << D_SH;

  always_comb begin
    // low halves are unsigned, high halves signed
    a_op = cmd_i.part[0] ? {coef[COEF_W-1], coef[COEF_W-1:HALF_W]}
                         : {1'b0, coef[HALF_W-1:0]};
    if (cmd_i.den) begin
      b_op = cmd_i.part[1] ? {d_word[COEF_W-1], d_word[COEF_W-1:HALF_W]}
                           : {1'b0, d_word[HALF_W-1:0]};
      sh_d = SHIFT_W'({1'b0, cmd_i.part[0]} + {1'b0, cmd_i.part[1]}) * SHIFT_W'(HALF_W);
    end else begin
      b_op = MUL_W'(x_sel);
      sh_d = cmd_i.part[0] ? SHIFT_W'(NUM_SH_HI) : SHIFT_W'(NUM_SH_LO);
    end
  end

  assign prod_d = a_op * b_op;

  // accumulate stage: feedback products are subtracted
  assign ext   = ACC_W'(prod_q) << sh_q;
  assign acc_d = neg_q ? (acc_q - ext) : (acc_q + ext);

  // accumulator -> Q8.(ST-8), round half up, saturate
  assign y_rnd = acc_q + (ACC_W'(1) << (Y_SH - 1));
  assign y_shr = $signed(y_rnd) >>> Y_SH;
  assign y_top = y_shr[ACC_W-1:STATE_WIDTH-1];
  assign y_fit = (&y_top) | ~(|y_top);
  assign y_d   = y_fit ? y_shr[STATE_WIDTH-1:0]
               : (y_shr[ACC_W-1] ? {1'b1, {(STATE_WIDTH-1){1'b0}}}
                                 : {1'b0, {(STATE_WIDTH-1){1'b1}}});

  // Q8.(ST-8) -> Q1.(SW-1), round half up, saturate
  assign s_rnd = EXT_W'(y_q) + (EXT_W'(1) << (S_SH - 1));
  assign s_shr = $signed(s_rnd) >>> S_SH;
  assign s_top = s_shr[EXT_W-1:SAMPLE_WIDTH-1];
  assign s_fit = (&s_top) | ~(|s_top);
  assign s_d   = s_fit ? s_shr[SAMPLE_WIDTH-1:0]
               : (s_shr[EXT_W-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                 : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});

  // multiplier output register
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    sh_q   <= sh_d;
    neg_q  <= cmd_i.den;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) x_q <= sample_in_i;
    if (cmd_i.round) y_q <= y_d;
    if (cmd_i.finish) begin
      sample_out_q <= s_d;
      clipped_q    <= ~s_fit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvld_q      <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pvld_q <= cmd_i.issue;
      if (cmd_i.start) begin
        acc_q <= '0;
      end else if (pvld_q) begin
        acc_q <= acc_d;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // histories shift once per sample, after its sum is done
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < IN_DEPTH; i++) in_hist_q[i] <= '0;
      for (int i = 0; i < OUT_DEPTH; i++) out_hist_q[i] <= '0;
    end else if (cmd_i.round) begin
      in_hist_q[0]  <= x_q;
      out_hist_q[0] <= y_d;
      for (int i = 1; i < IN_DEPTH; i++) in_hist_q[i] <= in_hist_q[i-1];
      for (int i = 1; i < OUT_DEPTH; i++) out_hist_q[i] <= out_hist_q[i-1];
    end
  end

  assign out_free_o   = ~out_valid_q | out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

endmodule

`default_nettype wire

// File: src/iir_lowpass_direct_form1.sv
// 8th-order Butterworth lowpass IIR, direct form I: one sample in (signed
// Q1.23), one filtered sample out, rounded half up and saturated, with a clip
// flag. All products of the 64-bit Q8.56 coefficients are summed exactly in a
// 128-bit accumulator; the output history is kept as Q8.56. One sample is
// processed at a time through a single 33x33 multiplier: 2 passes per
// numerator tap and 4 per feedback tap, plus the accept, drain, rounding and
// output load steps. The result sits in an output register, so the next
// sample is taken while it waits; a finished sample holds the sequencer only
// if the previous result has still not been taken. Histories clear on reset.
`timescale 1ns / 1ps
`default_nettype none

module iir_lowpass_direct_form1 import iir_lpf_pkg::*; #(
  parameter int NUM_TAPS     = NUM_TAPS_DEF,
  parameter int DEN_TAPS     = DEN_TAPS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  iir_lpf_in_if.sink    in_i,
  iir_lpf_out_if.source out_o
);

  cmd_t                    cmd;
  logic                    in_ready;
  logic                    out_free;
  logic                    out_valid;
  logic [SAMPLE_WIDTH-1:0] sample_out;
  logic                    clipped;

  iir_lpf_ctrl #(
    .NUM_TAPS (NUM_TAPS),
    .DEN_TAPS (DEN_TAPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  iir_lpf_dp #(
    .NUM_TAPS     (NUM_TAPS),
    .DEN_TAPS     (DEN_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sample_in_i  (in_i.sample_in),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_valid),
    .sample_out_o (sample_out),
    .clipped_o    (clipped),
    .out_free_o   (out_free)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.sample_out = sample_out;
  assign out_o.clipped    = clipped;

endmodule

`default_nettype wire

// File: tb/sv/iir_lowpass_direct_form1_checker.sv
// Scoreboard for the 8th-order Butterworth lowpass: watches both sample channels,
// runs a bit-exact fixed-point model of the filter and compares every output beat.
// Depends on iir_lpf_pkg and the channel interfaces in iir_lpf_if.sv.
`timescale 1ns / 1ps

module iir_lowpass_direct_form1_checker import iir_lpf_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  iir_lpf_in_if         in_mon_i,
  iir_lpf_out_if        out_mon_i,
  output int            errors_o,
  output int            pending_o
);

  localparam int SW        = SAMPLE_WIDTH_DEF;
  localparam int HIST      = 8;
  localparam int IN_SHIFT  = 57 - SW;       // Q1.23 -> Q8.56
  localparam int ACC_SHIFT = 120 - 64;      // Q16.112 -> Q8.56
  localparam int OUT_SHIFT = 64 - 7 - SW;   // Q8.56 -> Q1.23

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic signed [SW-1:0] sample_out;
    logic                 clipped;
  } lpf_result_t;

  // b0..b4 (numerator is symmetric) and a1..a8 as decimal mantissa / 10^exp
  localparam longint unsigned NUM_MANT [5] = '{
    64'd5285919273356, 64'd4228735418685, 64'd148005739654,
    64'd2960114793079, 64'd3700143491349
  };
  localparam int NUM_EXP [5] = '{24, 23, 21, 22, 22};
  localparam longint unsigned DEN_MANT [8] = '{
    64'd7590687094437, 64'd2521812014273, 64'd4789335424121, 64'd5687002612068,
    64'd4323484983982, 64'd2055056514782, 64'd558382515593, 64'd6640049215241
  };
  localparam int DEN_EXP [8] = '{12, 11, 11, 11, 11, 11, 11, 13};

  logic signed [63:0]   num_coef [9];
  logic signed [63:0]   den_coef [9];
  logic signed [SW-1:0] x_hist [HIST];
  logic signed [63:0]   y_hist [HIST];
  lpf_result_t          due_outputs [$];
  int                   mismatch_count;

  // round(mant * 2^56 / 10^exp), ties away from zero
  function automatic logic signed [63:0] coef_q56(input longint unsigned mant,
                                                   input int exp10, input bit neg);
    logic [127:0] scale;
    logic [127:0] q;
    logic [63:0]  m;
    int           k;
    scale = 128'd1;
    for (k = 0; k < exp10; k++) scale = scale * 128'd10;
    q = ((128'(mant) << 56) + (scale >> 1)) / scale;
    m = q[63:0];
    if (neg) m = -m;
    return m;
  endfunction

  function automatic wide_t mul_wide(input logic signed [63:0] a,
                                     input logic signed [63:0] b);
    wide_t wa;
    wide_t wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  // one filter update: predicts the output beat and shifts both histories
  function automatic lpf_result_t lowpass_step(input logic signed [SW-1:0] x);
    wide_t              acc;
    wide_t              r;
    logic signed [63:0] t;
    logic signed [63:0] y;
    lpf_result_t        res;
    int                 j;
    t = x;
    acc = mul_wide(num_coef[0], t <<< IN_SHIFT);
    for (j = 0; j < HIST; j++) begin
      t = x_hist[j];
      acc = acc + mul_wide(num_coef[j+1], t <<< IN_SHIFT);
      acc = acc - mul_wide(den_coef[j+1], y_hist[j]);
    end
    r = acc + (wide_t'(1) <<< (ACC_SHIFT - 1));
    r = r >>> ACC_SHIFT;
    if (&r[127:63] || ~|r[127:63]) begin
      y = r[63:0];
    end else begin
      y = r[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    r = y;
    r = r + (wide_t'(1) <<< (OUT_SHIFT - 1));
    r = r >>> OUT_SHIFT;
    if (&r[127:SW-1] || ~|r[127:SW-1]) begin
      res.sample_out = r[SW-1:0];
      res.clipped    = 1'b0;
    end else begin
      res.sample_out = r[127] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      res.clipped    = 1'b1;
    end
    for (j = HIST - 1; j > 0; j--) begin
      x_hist[j] = x_hist[j-1];
      y_hist[j] = y_hist[j-1];
    end
    x_hist[0] = x;
    y_hist[0] = y;
    return res;
  endfunction

  initial begin
    int i;
    for (i = 0; i < 5; i++) begin
      num_coef[i]     = coef_q56(NUM_MANT[i], NUM_EXP[i], 1'b0);
      num_coef[8 - i] = num_coef[i];
    end
    den_coef[0] = '0;
    // feedback signs alternate, a1 negative
    for (i = 1; i < 9; i++) den_coef[i] = coef_q56(DEN_MANT[i-1], DEN_EXP[i-1], i[0]);
  end

  always @(posedge clk_i or negedge rst_ni) begin
    lpf_result_t want;
    int          j;
    if (!rst_ni) begin
      for (j = 0; j < HIST; j++) begin
        x_hist[j] = '0;
        y_hist[j] = '0;
      end
      due_outputs.delete();
      mismatch_count = 0;
    end else begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        due_outputs.push_back(lowpass_step(in_mon_i.sample_in));
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (due_outputs.size() == 0) begin
          $display("%0t: output beat with nothing due, expected none, got %0d clipped %0b",
                   $time, out_mon_i.sample_out, out_mon_i.clipped);
          mismatch_count++;
        end else begin
          want = due_outputs.pop_front();
          if (out_mon_i.sample_out !== want.sample_out) begin
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want.sample_out, out_mon_i.sample_out);
            mismatch_count++;
          end
          if (out_mon_i.clipped !== want.clipped) begin
            $display("%0t: clipped mismatch, expected %0b, got %0b",
                     $time, want.clipped, out_mon_i.clipped);
            mismatch_count++;
          end
        end
      end
    end
    errors_o  <= mismatch_count;
    pending_o <= due_outputs.size();
  end

endmodule

// File: tb/sv/iir_lowpass_direct_form1_tb.sv
// Top of the lowpass IIR testbench: clock, reset, sample stimulus with random
// idling on both channels, and the final verdict from the checker's counts.
// Depends on iir_lpf_pkg, iir_lpf_if.sv, the checker and the filter RTL.
`timescale 1ns / 1ps

module iir_lowpass_direct_form1_tb import iir_lpf_pkg::*;;

  localparam int          SW           = SAMPLE_WIDTH_DEF;
  localparam int          RANDOM_ITEMS = 950;
  localparam int          LONG_HOLD    = 700;
  localparam int          DRAIN_CYCLES = 120;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam logic [SW-1:0] SMP_MAX    = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SMP_MIN    = {1'b1, {(SW-1){1'b0}}};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   results_due;
  int   cycle_count = 0;
  bit   no_idle = 1'b0;
  bit   long_stall_req = 1'b0;

  iir_lpf_in_if  in_if ();
  iir_lpf_out_if out_if ();

  iir_lowpass_direct_form1 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  iir_lowpass_direct_form1_checker checker_inst (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon_i  (in_if),
    .out_mon_i (out_if),
    .errors_o  (fail_count),
    .pending_o (results_due)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_sample(input logic [SW-1:0] s);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // output side: random ready pattern, plus one long hold-off on request
  initial begin
    int n;
    out_if.ready <= 1'b0;
    wait (rst_ni == 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (no_idle) begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        n = idle_len();
        if (n > 0) begin
          out_if.ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [SW-1:0] directed [18];
    logic [SW-1:0] level;
    bit            last_high;
    int            i;
    int            len;
    int            kind;
    int            sent;
    int            seg;
    directed = '{
      '0, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, 24'h000001, 24'hFFFFFF, '0,
      24'h555555, 24'hAAAAAA, 24'h0F0F0F, 24'hF0F0F0, SMP_MIN, SMP_MIN,
      SMP_MAX, SMP_MAX, '0, '0
    };
    in_if.valid     <= 1'b0;
    in_if.sample_in <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_sample(directed[i]);

    sent      = 0;
    seg       = 0;
    last_high = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      kind    = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 4) == 0);
      if (seg == 2) begin
        // output stalls long while input keeps coming: block must back up
        long_stall_req = 1'b1;
        no_idle        = 1'b1;
        kind           = 50;
      end
      if (kind < 30) begin
        // long step at or near full scale; flipping sides gives overshoot past full scale
        len = $urandom_range(120, 240);
        if ($urandom_range(0, 3) != 0) last_high = !last_high;
        else last_high = $urandom_range(0, 1);
        if ($urandom_range(0, 4) == 0)
          level = last_high ? SW'($urandom_range(24'h600000, 24'h7FFFFF))
                            : SW'(-$urandom_range(24'h600000, 24'h800000));
        else
          level = last_high ? SMP_MAX : SMP_MIN;
      end else begin
        len = (seg == 2) ? 40 : $urandom_range(10, 60);
      end
      for (i = 0; i < len && sent < RANDOM_ITEMS; i++) begin
        if (kind < 30) send_sample(level);
        else if (kind < 75) send_sample(SW'($urandom()));
        else if (kind < 90) send_sample(SW'($urandom_range(0, 511) - 256));
        else send_sample(($urandom_range(0, 1) != 0) ? SMP_MAX : SMP_MIN);
        sent++;
      end
      seg++;
    end
    in_if.valid <= 1'b0;
    no_idle = 1'b0;
    // let the checker count the last accepted beat
    @(posedge clk_i);

    while (results_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && results_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
